// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the cylinder collision resolver RTL.
// Expects clk and active-low arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCR_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ccr assertion failed");

// Next-cycle implication.
`define CCR_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ccr assertion failed");

`endif

// ===== hw/rtl/ccr_pkg.sv =====
// Shared constants for the cylinder collision resolver.
// No dependencies.
`timescale 1ns / 1ps

package ccr_pkg;

	localparam int COORD_W   = 32;
	localparam int CONTACT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CONTACT_W-1:0] CONTACT_NONE   = 2'd0;
	localparam logic [CONTACT_W-1:0] CONTACT_TOP    = 2'd1;
	localparam logic [CONTACT_W-1:0] CONTACT_BOTTOM = 2'd2;
	localparam logic [CONTACT_W-1:0] CONTACT_SIDE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CYL_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CYL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PUSH_BACK  = 2'd2;

endpackage

// ===== hw/rtl/cylinder_collision_resolver.sv =====
// Cylinder collision resolver top level: crossing tests, squares, square
// roots, push scaling and saturation. Uses ccr_pkg, ccr_delay,
// ccr_isqrt_pipe, ccr_div_pipe and assert_macros.svh.
//
//   channel | signals                          | direction
//   in      | in_valid, in_stall, item fields  | into block
//   out     | out_valid, out_stall, results    | out of block
//   cfg     | cfg_we, cfg_index, cfg_wdata     | into block
//
// One transaction per cycle sustained while the output is not stalled; the
// square root and divider each produce one result bit per stage.
// Reset clears valid bits, output valid and configuration registers.
// A stalled output freezes the whole pipeline; in_stall follows it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cylinder_collision_resolver #(
	parameter int COORD_WIDTH = ccr_pkg::COORD_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              skip_parent,
	input  logic signed [COORD_WIDTH-1:0]     rel_x,
	input  logic signed [COORD_WIDTH-1:0]     rel_y,
	input  logic signed [COORD_WIDTH-1:0]     rel_z,
	input  logic signed [COORD_WIDTH-1:0]     rel_prev_y,
	input  logic signed [COORD_WIDTH-1:0]     cyl_dx,
	input  logic signed [COORD_WIDTH-1:0]     cyl_dy,
	input  logic signed [COORD_WIDTH-1:0]     cyl_dz,
	input  logic [COORD_WIDTH-2:0]            obj_radius,
	input  logic [COORD_WIDTH-2:0]            obj_height,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ccr_pkg::CONTACT_W-1:0]     contact,
	output logic signed [COORD_WIDTH-1:0]     new_rel_x,
	output logic signed [COORD_WIDTH-1:0]     new_rel_y,
	output logic signed [COORD_WIDTH-1:0]     new_rel_z,
	output logic                              stop_vertical,
	input  logic                              cfg_we,
	input  logic [ccr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-2:0]            cfg_wdata
);

	localparam int CW = COORD_WIDTH;
	localparam int EW = CW + 2;
	localparam int PW = 2 * CW;

	typedef struct packed {
		logic                 skip;
		logic                 top;
		logic                 bot;
		logic                 sidey;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dz;
		logic [CW-2:0]        oh;
		logic [CW-1:0]        r;
		logic [CW-1:0]        magx;
		logic [CW-1:0]        magz;
	} item_t;

	typedef struct packed {
		item_t it;
		logic  le;
		logic  lt;
	} tst_t;

	typedef struct packed {
		tst_t t;
		logic l3nz;
	} fin_t;

	// configuration
	logic [CW-2:0] cyl_radius_q, cyl_height_q;
	logic          push_back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_radius_q <= '0;
			cyl_height_q <= '0;
			push_back_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ccr_pkg::REG_CYL_RADIUS: cyl_radius_q <= cfg_wdata;
				ccr_pkg::REG_CYL_HEIGHT: cyl_height_q <= cfg_wdata;
				ccr_pkg::REG_PUSH_BACK:  push_back_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: crossing tests, magnitudes, combined radius
	logic signed [EW-1:0] y_e, py_e, dy_e, oh_e, hh_e, hmd_e, ndy_e, yoh_e, pyoh_e;
	item_t                it_in;
	logic [CW-1:0]        magy_in;

	assign y_e    = $signed({{2{rel_y[CW-1]}}, rel_y});
	assign py_e   = $signed({{2{rel_prev_y[CW-1]}}, rel_prev_y});
	assign dy_e   = $signed({{2{cyl_dy[CW-1]}}, cyl_dy});
	assign oh_e   = $signed({3'b000, obj_height});
	assign hh_e   = $signed({3'b000, cyl_height_q});
	assign hmd_e  = hh_e - dy_e;
	assign ndy_e  = -dy_e;
	assign yoh_e  = y_e + oh_e;
	assign pyoh_e = py_e + oh_e;

	always_comb begin
		it_in.skip  = skip_parent;
		it_in.top   = (py_e >= hh_e && y_e <= hh_e) || (py_e >= hmd_e && y_e <= hmd_e);
		it_in.bot   = (pyoh_e <= 0 && yoh_e > 0) || (py_e >= ndy_e && y_e < ndy_e);
		it_in.sidey = (y_e <= hh_e) && (yoh_e >= 0);
		it_in.x     = rel_x;
		it_in.y     = rel_y;
		it_in.z     = rel_z;
		it_in.dx    = cyl_dx;
		it_in.dz    = cyl_dz;
		it_in.oh    = obj_height;
		it_in.r     = {1'b0, cyl_radius_q} + {1'b0, obj_radius};
		it_in.magx  = rel_x[CW-1] ? (~rel_x + 1'b1) : rel_x;
		it_in.magz  = rel_z[CW-1] ? (~rel_z + 1'b1) : rel_z;
		magy_in     = rel_y[CW-1] ? (~rel_y + 1'b1) : rel_y;
	end

	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	item_t         it_s1, it_s2, it_s3, it_s4;
	logic [CW-1:0] magy_s1;
	logic [PW-1:0] x2_s2, z2_s2, y2_s2, r2_s2;
	logic [PW-1:0] s2_s3, y2_s3, r2_s3;
	logic [PW-1:0] s2_s4, s3_s4;
	logic          le_s4, lt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1   <= it_in;
			magy_s1 <= magy_in;
			// stage 2: squares
			it_s2   <= it_s1;
			x2_s2   <= it_s1.magx * it_s1.magx;
			z2_s2   <= it_s1.magz * it_s1.magz;
			y2_s2   <= magy_s1 * magy_s1;
			r2_s2   <= it_s1.r * it_s1.r;
			// stage 3: horizontal distance squared
			it_s3   <= it_s2;
			s2_s3   <= x2_s2 + z2_s2;
			y2_s3   <= y2_s2;
			r2_s3   <= r2_s2;
			// stage 4: 3D distance squared, radius compares
			it_s4   <= it_s3;
			s2_s4   <= s2_s3;
			s3_s4   <= s2_s3 + y2_s3;
			le_s4   <= s2_s3 <= r2_s3;
			lt_s4   <= s2_s3 < r2_s3;
		end
	end

	// square roots of horizontal and 3D distance squared
	logic [CW-1:0] len_q, l3_q;
	tst_t          tst_s4, tst_d1;
	logic          v_d1;

	assign tst_s4 = '{it: it_s4, le: le_s4, lt: lt_s4};

	ccr_isqrt_pipe #(.IN_W(PW)) u_sqrt_len (
		.clk(clk), .en(adv), .din(s2_s4), .root(len_q)
	);

	ccr_isqrt_pipe #(.IN_W(PW)) u_sqrt_l3 (
		.clk(clk), .en(adv), .din(s3_s4), .root(l3_q)
	);

	ccr_delay #(.W($bits(tst_t)), .DEPTH(CW)) u_dly_sqrt (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din_valid(v_s4), .din(tst_s4),
		.dout_valid(v_d1), .dout(tst_d1)
	);

	// stages 5 to 7: push amount, scaled offsets, rounding bias
	tst_t          tst_s5, tst_s6;
	fin_t          fin_s7;
	logic [CW-1:0] l3_s5, l3_s6, l3_s7, amt_s5;
	logic [PW-1:0] mx_s6, mz_s6, nx_s7, nz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_d1;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tst_s5 <= tst_d1;
			l3_s5  <= l3_q;
			amt_s5 <= tst_d1.it.r - len_q;
			tst_s6 <= tst_s5;
			l3_s6  <= l3_s5;
			mx_s6  <= tst_s5.it.magx * amt_s5;
			mz_s6  <= tst_s5.it.magz * amt_s5;
			fin_s7 <= '{t: tst_s6, l3nz: (l3_s6 != '0)};
			l3_s7  <= l3_s6;
			nx_s7  <= mx_s6 + {{(CW+1){1'b0}}, l3_s6[CW-1:1]};
			nz_s7  <= mz_s6 + {{(CW+1){1'b0}}, l3_s6[CW-1:1]};
		end
	end

	logic [CW-1:0] qx, qz;
	fin_t          fin_f;
	logic          v_f;

	ccr_div_pipe #(.N_W(PW), .D_W(CW), .Q_W(CW)) u_div_x (
		.clk(clk), .en(adv), .num(nx_s7), .den(l3_s7), .quot(qx)
	);

	ccr_div_pipe #(.N_W(PW), .D_W(CW), .Q_W(CW)) u_div_z (
		.clk(clk), .en(adv), .num(nz_s7), .den(l3_s7), .quot(qz)
	);

	ccr_delay #(.W($bits(fin_t)), .DEPTH(CW)) u_dly_div (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din_valid(v_s7), .din(fin_s7),
		.dout_valid(v_f), .dout(fin_f)
	);

	// final: pick contact, apply correction, saturate
	function automatic logic [CW-1:0] sat_coord(input logic [EW-1:0] v);
		logic [CW-1:0] res;
		if (v[EW-1:CW-1] == '0 || v[EW-1:CW-1] == '1) begin
			res = v[CW-1:0];
		end else if (v[EW-1]) begin
			res = {1'b1, {(CW-1){1'b0}}};
		end else begin
			res = {1'b0, {(CW-1){1'b1}}};
		end
		return res;
	endfunction

	logic [ccr_pkg::CONTACT_W-1:0] contact_f;
	logic [EW-1:0]                 x_f, y_f, z_f, dx_f, dz_f, qx_f, qz_f;
	logic [EW-1:0]                 nx_f, ny_f, nz_f;
	logic                          stop_f;

	assign x_f  = {{2{fin_f.t.it.x[CW-1]}}, fin_f.t.it.x};
	assign y_f  = {{2{fin_f.t.it.y[CW-1]}}, fin_f.t.it.y};
	assign z_f  = {{2{fin_f.t.it.z[CW-1]}}, fin_f.t.it.z};
	assign dx_f = {{2{fin_f.t.it.dx[CW-1]}}, fin_f.t.it.dx};
	assign dz_f = {{2{fin_f.t.it.dz[CW-1]}}, fin_f.t.it.dz};
	assign qx_f = {2'b00, qx};
	assign qz_f = {2'b00, qz};

	always_comb begin
		contact_f = ccr_pkg::CONTACT_NONE;
		if (!fin_f.t.it.skip) begin
			if (fin_f.t.it.top) begin
				if (fin_f.t.le) contact_f = ccr_pkg::CONTACT_TOP;
			end else if (fin_f.t.it.bot) begin
				if (fin_f.t.le) contact_f = ccr_pkg::CONTACT_BOTTOM;
			end
			// a top crossing with no horizontal overlap still gets the side test
			if (contact_f == ccr_pkg::CONTACT_NONE && fin_f.t.lt && fin_f.t.it.sidey)
				contact_f = ccr_pkg::CONTACT_SIDE;
		end
		nx_f   = x_f;
		ny_f   = y_f;
		nz_f   = z_f;
		stop_f = 1'b0;
		if (push_back_q) begin
			case (contact_f)
				ccr_pkg::CONTACT_TOP: begin
					nx_f   = x_f + dx_f;
					nz_f   = z_f + dz_f;
					ny_f   = {3'b000, cyl_height_q};
					stop_f = 1'b1;
				end
				ccr_pkg::CONTACT_BOTTOM: begin
					ny_f   = -{3'b000, fin_f.t.it.oh};
					stop_f = 1'b1;
				end
				ccr_pkg::CONTACT_SIDE: begin
					if (fin_f.l3nz) begin
						nx_f = fin_f.t.it.x[CW-1] ? x_f - qx_f : x_f + qx_f;
						nz_f = fin_f.t.it.z[CW-1] ? z_f - qz_f : z_f + qz_f;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			contact       <= contact_f;
			new_rel_x     <= sat_coord(nx_f);
			new_rel_y     <= sat_coord(ny_f);
			new_rel_z     <= sat_coord(nz_f);
			stop_vertical <= stop_f;
		end
	end

	`CCR_ASSERT_IMP(a_stop_needs_vert, out_valid && stop_vertical, contact == ccr_pkg::CONTACT_TOP || contact == ccr_pkg::CONTACT_BOTTOM)
	`CCR_ASSERT_IMP(a_detect_only, out_valid && !push_back_q, !stop_vertical)
	`CCR_ASSERT_IMP(a_top_height, out_valid && stop_vertical && contact == ccr_pkg::CONTACT_TOP, new_rel_y == {1'b0, cyl_height_q})
	`CCR_ASSERT_NXT(a_out_load, adv && v_f, out_valid)

endmodule

// ===== hw/rtl/ccr_delay.sv =====
// Enable-gated delay line for valid bits and sideband data.
// No dependencies.
`timescale 1ns / 1ps

module ccr_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         din_valid,
	input  logic [W-1:0] din,
	output logic         dout_valid,
	output logic [W-1:0] dout
);

	logic         v_q [DEPTH];
	logic [W-1:0] d_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) v_q[k] <= 1'b0;
		end else if (en) begin
			v_q[0] <= din_valid;
			for (int k = 1; k < DEPTH; k++) v_q[k] <= v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) d_q[k] <= d_q[k-1];
		end
	end

	assign dout_valid = v_q[DEPTH-1];
	assign dout       = d_q[DEPTH-1];

endmodule

// ===== hw/rtl/ccr_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
// No dependencies.
`timescale 1ns / 1ps

module ccr_isqrt_pipe #(
	parameter int IN_W = 64
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   din,
	output logic [IN_W/2-1:0] root
);

	localparam int NST = IN_W / 2;

	logic [IN_W-1:0] rem_q   [NST-1];
	logic [IN_W-1:0] root_q  [NST];
	logic [IN_W-1:0] rem_pv  [NST];
	logic [IN_W-1:0] root_pv [NST];
	logic [IN_W-1:0] rem_d   [NST];
	logic [IN_W-1:0] root_d  [NST];
	logic [IN_W-1:0] trial   [NST];
	logic [IN_W-1:0] bitv    [NST];

	assign rem_pv[0]  = din;
	assign root_pv[0] = '0;
	for (genvar k = 1; k < NST; k++) begin : g_link
		assign rem_pv[k]  = rem_q[k-1];
		assign root_pv[k] = root_q[k-1];
	end

	always_comb begin
		for (int k = 0; k < NST; k++) begin
			bitv[k]  = {{(IN_W-1){1'b0}}, 1'b1} << (2 * (NST - 1 - k));
			trial[k] = root_pv[k] + bitv[k];
			if (rem_pv[k] >= trial[k]) begin
				rem_d[k]  = rem_pv[k] - trial[k];
				root_d[k] = (root_pv[k] >> 1) + bitv[k];
			end else begin
				rem_d[k]  = rem_pv[k];
				root_d[k] = root_pv[k] >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++) root_q[k] <= root_d[k];
			for (int k = 0; k < NST - 1; k++) rem_q[k] <= rem_d[k];
		end
	end

	assign root = root_q[NST-1][NST-1:0];

endmodule

// ===== hw/rtl/ccr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Quotient must fit Q_W bits. No dependencies.
`timescale 1ns / 1ps

module ccr_div_pipe #(
	parameter int N_W = 64,
	parameter int D_W = 32,
	parameter int Q_W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic [Q_W-1:0] quot
);

	logic [N_W-1:0] rem_q  [Q_W-1];
	logic [D_W-1:0] den_q  [Q_W-1];
	logic [Q_W-1:0] quo_q  [Q_W];
	logic [N_W-1:0] rem_pv [Q_W];
	logic [D_W-1:0] den_pv [Q_W];
	logic [Q_W-1:0] quo_pv [Q_W];
	logic [N_W-1:0] rem_d  [Q_W];
	logic [Q_W-1:0] quo_d  [Q_W];
	logic [N_W-1:0] shd    [Q_W];

	assign rem_pv[0] = num;
	assign den_pv[0] = den;
	assign quo_pv[0] = '0;
	for (genvar k = 1; k < Q_W; k++) begin : g_link
		assign rem_pv[k] = rem_q[k-1];
		assign den_pv[k] = den_q[k-1];
		assign quo_pv[k] = quo_q[k-1];
	end

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			shd[k] = {{(N_W-D_W){1'b0}}, den_pv[k]} << (Q_W - 1 - k);
			if (rem_pv[k] >= shd[k]) begin
				rem_d[k] = rem_pv[k] - shd[k];
				quo_d[k] = quo_pv[k] | ({{(Q_W-1){1'b0}}, 1'b1} << (Q_W - 1 - k));
			end else begin
				rem_d[k] = rem_pv[k];
				quo_d[k] = quo_pv[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) quo_q[k] <= quo_d[k];
			for (int k = 0; k < Q_W - 1; k++) begin
				rem_q[k] <= rem_d[k];
				den_q[k] <= den_pv[k];
			end
		end
	end

	assign quot = quo_q[Q_W-1];

endmodule

// ===== bench/tb_cylinder_collision_resolver.sv =====
// Self-checking bench for cylinder_collision_resolver: random and directed pairs,
// with a bit-exact contact/push predictor and a scoreboard of expected results.
// Depends on ccr_pkg and the resolver RTL only.
`timescale 1ns / 1ps

module tb_cylinder_collision_resolver;

	localparam longint ONE = 64'sd65536;
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;
	localparam int LATENCY = 2 * ccr_pkg::COORD_W + 8;

	typedef struct packed {
		logic        skip_parent;
		logic [31:0] x, y, z, py, dx, dy, dz;
		logic [30:0] orad, oh;
	} pair_t;

	typedef struct packed {
		logic [1:0]  contact;
		logic [31:0] nx, ny, nz;
		logic        stopv;
	} resolve_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [ccr_pkg::CFG_IDX_W-1:0] cfg_index = ccr_pkg::REG_CYL_RADIUS;
	logic [30:0] cfg_wdata = '0;
	pair_t cur = '0;
	logic [1:0]  contact;
	logic [31:0] new_rel_x, new_rel_y, new_rel_z;
	logic        stop_vertical;

	// shadow of the block's registers
	longint unsigned sh_radius = 0, sh_height = 0;
	bit sh_push = 0;
	bit calm = 0;

	pair_t    pending_pairs[$];
	resolve_t expected_res[$];
	int mismatches = 0;

	cylinder_collision_resolver u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.skip_parent(cur.skip_parent),
		.rel_x(cur.x), .rel_y(cur.y), .rel_z(cur.z), .rel_prev_y(cur.py),
		.cyl_dx(cur.dx), .cyl_dy(cur.dy), .cyl_dz(cur.dz),
		.obj_radius(cur.orad), .obj_height(cur.oh),
		.out_valid(out_valid), .out_stall(out_stall),
		.contact(contact), .new_rel_x(new_rel_x), .new_rel_y(new_rel_y),
		.new_rel_z(new_rel_z), .stop_vertical(stop_vertical),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > MAX32) return 32'h7fffffff;
		if (v < MIN32) return 32'h80000000;
		return v[31:0];
	endfunction

	// rounded c*amt/l3, ties away from zero
	function automatic longint scaled_push(longint c, longint unsigned amt,
			longint unsigned l3);
		longint unsigned q;
		q = (abs64(c) * amt + l3 / 2) / l3;
		return c < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic resolve_t resolve_pair(pair_t p);
		resolve_t res;
		longint x, y, z, py, dx, dy, dz, oh, hh;
		longint unsigned r, r2, s2, len, l3;
		bit top, bot;
		x = longint'($signed(p.x));
		y = longint'($signed(p.y));
		z = longint'($signed(p.z));
		py = longint'($signed(p.py));
		dx = longint'($signed(p.dx));
		dy = longint'($signed(p.dy));
		dz = longint'($signed(p.dz));
		oh = longint'({33'd0, p.oh});
		hh = longint'(sh_height);
		r = sh_radius + {33'd0, p.orad};
		r2 = r * r;
		s2 = abs64(x) * abs64(x) + abs64(z) * abs64(z);
		res.contact = ccr_pkg::CONTACT_NONE;
		res.stopv = 1'b0;
		res.nx = clamp32(x);
		res.ny = clamp32(y);
		res.nz = clamp32(z);
		if (!p.skip_parent) begin
			top = (py >= hh && y <= hh) || (py >= hh - dy && y <= hh - dy);
			bot = (py + oh <= 0 && y + oh > 0) || (py >= -dy && y < -dy);
			if (top) begin
				if (s2 <= r2) begin
					res.contact = ccr_pkg::CONTACT_TOP;
					if (sh_push) begin
						res.nx = clamp32(x + dx);
						res.nz = clamp32(z + dz);
						res.ny = clamp32(hh);
						res.stopv = 1'b1;
					end
				end
			end else if (bot && s2 <= r2) begin
				res.contact = ccr_pkg::CONTACT_BOTTOM;
				if (sh_push) begin
					res.ny = clamp32(-oh);
					res.stopv = 1'b1;
				end
			end
			if (res.contact == ccr_pkg::CONTACT_NONE && s2 < r2
					&& y <= hh && y + oh >= 0) begin
				res.contact = ccr_pkg::CONTACT_SIDE;
				if (sh_push) begin
					len = floor_sqrt(s2);
					l3 = floor_sqrt(s2 + abs64(y) * abs64(y));
					if (l3 != 0) begin
						res.nx = clamp32(x + scaled_push(x, r - len, l3));
						res.nz = clamp32(z + scaled_push(z, r - len, l3));
					end
				end
			end
		end
		return res;
	endfunction

	task automatic add_pair(bit sp, longint x, longint y, longint z, longint py,
			longint dx, longint dy, longint dz, longint orad, longint oh);
		pair_t p;
		p.skip_parent = sp;
		p.x = clamp32(x);
		p.y = clamp32(y);
		p.z = clamp32(z);
		p.py = clamp32(py);
		p.dx = clamp32(dx);
		p.dy = clamp32(dy);
		p.dz = clamp32(dz);
		p.orad = (orad < 0) ? 31'd0 : (orad > MAX32 ? 31'h7fffffff : orad[30:0]);
		p.oh = (oh < 0) ? 31'd0 : (oh > MAX32 ? 31'h7fffffff : oh[30:0]);
		pending_pairs.push_back(p);
	endtask

	function automatic longint spread(longint span);
		if (span <= 0) return 0;
		if (span > 64'sd1073741824) span = 64'sd1073741824;
		return longint'($urandom_range(32'(2 * span))) - span;
	endfunction

	// mostly well-formed crossings and overlaps around the current collider
	task automatic add_random_pair();
		longint hh, r, oh, orad, x, z, y, py, dy;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			add_pair($urandom_range(0, 1), longint'($signed($urandom)),
				longint'($signed($urandom)), longint'($signed($urandom)),
				longint'($signed($urandom)), longint'($signed($urandom)),
				longint'($signed($urandom)), longint'($signed($urandom)),
				longint'($urandom & 32'h7fffffff), longint'($urandom & 32'h7fffffff));
			return;
		end
		hh = longint'(sh_height);
		orad = $urandom_range(0, 3) == 0 ? longint'($urandom & 32'h7fffffff)
			: longint'($urandom_range(0, 3 * 65536));
		oh = longint'($urandom_range(0, 4 * 65536));
		r = longint'(sh_radius) + orad;
		x = spread(r * 3 / 4);
		z = spread(r * 3 / 4);
		dy = $urandom_range(0, 1) ? 0 : spread(ONE);
		case (kind % 4)
			0: begin
				py = hh + longint'($urandom_range(0, 2 * 65536));
				y = hh - longint'($urandom_range(0, 2 * 65536));
			end
			1: begin
				py = -oh - longint'($urandom_range(0, 2 * 65536));
				y = -oh + longint'($urandom_range(1, 2 * 65536));
			end
			2: begin
				y = hh - longint'($urandom_range(0, 32'(hh + oh > MAX32 ? MAX32 : hh + oh)));
				py = y + spread(ONE / 4);
			end
			default: begin
				y = spread(hh + ONE);
				py = spread(hh + ONE);
			end
		endcase
		add_pair($urandom_range(0, 15) == 0, x, y, z, py, spread(2 * ONE), dy,
			spread(2 * ONE), orad, oh);
	endtask

	task automatic wait_quiet();
		while (pending_pairs.size() != 0 || in_valid || expected_res.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic set_collider(longint unsigned rad, longint unsigned hgt, bit pb);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ccr_pkg::REG_CYL_RADIUS;
		cfg_wdata <= rad[30:0];
		@(posedge clk);
		cfg_index <= ccr_pkg::REG_CYL_HEIGHT;
		cfg_wdata <= hgt[30:0];
		@(posedge clk);
		cfg_index <= ccr_pkg::REG_PUSH_BACK;
		cfg_wdata <= {30'd0, pb};
		@(posedge clk);
		cfg_we <= 1'b0;
		sh_radius = rad;
		sh_height = hgt;
		sh_push = pb;
	endtask

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_res.push_back(resolve_pair(cur));
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					cur <= pending_pairs.pop_front();
					in_valid <= 1'b1;
					send_gap = calm ? 0 : $urandom_range(0, 9);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and scoreboard
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		resolve_t exp_r, got;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{contact, new_rel_x, new_rel_y, new_rel_z, stop_vertical};
				if (expected_res.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: %p", got);
				end else begin
					exp_r = expected_res.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", exp_r, got);
					end
				end
				hold_cnt = calm ? 0 : $urandom_range(0, 9);
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		longint unsigned rads[5];
		longint unsigned hgts[5];
		bit pbs[5];
		rads = '{2 * 65536, 0, 64'h7fffffff, 32768, 3 * 65536};
		hgts = '{4 * 65536, 0, 64'h7fffffff, 65536, 32768};
		pbs = '{1, 1, 1, 0, 1};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		set_collider(rads[0], hgts[0], pbs[0]);
		// directed: parent skip, both top crossings, top miss, both bottom
		// crossings, side push, zero offset, saturation and field extremes
		add_pair(1, ONE, 3 * ONE, 0, 5 * ONE, 0, 0, 0, ONE, ONE);
		add_pair(0, ONE, 3 * ONE, 0, 5 * ONE, 100, 0, -100, ONE, ONE);
		add_pair(0, 0, 2 * ONE + 50000, ONE, 3 * ONE + 10000, 0, ONE, 0, 0, ONE);
		add_pair(0, 10 * ONE, 3 * ONE, 0, 5 * ONE, 0, 0, 0, ONE, ONE);
		add_pair(0, 0, -ONE / 2, ONE, -2 * ONE, 0, 0, 0, ONE, ONE);
		add_pair(0, ONE, ONE / 2, 0, ONE + ONE / 2, 0, -ONE, 0, ONE, ONE);
		add_pair(0, ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE);
		add_pair(0, -ONE / 3, ONE / 2, ONE / 5, ONE / 2, 0, 0, 0, 0, 0);
		add_pair(0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE);
		add_pair(0, 64'sh7fff0000, 5 * ONE, 0, 5 * ONE, MAX32, 0, MIN32,
			MAX32, ONE);
		add_pair(0, -64'sh7fff0000, 0, 0, 0, 0, 0, 0, MAX32, ONE);
		add_pair(0, MIN32, MIN32, MAX32, MAX32, MIN32, MAX32, MIN32, MAX32, MAX32);
		add_pair(0, MAX32, MAX32, MIN32, MIN32, MAX32, MIN32, MAX32, 0, 0);
		add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_pair(1, -1, -1, -1, -1, -1, -1, -1, MAX32, MAX32);
		add_pair(0, 0, MIN32, 0, MAX32, 0, 0, 0, MAX32, MAX32);
		for (int ph = 0; ph < 5; ph++) begin
			if (ph != 0) begin
				// hold off the sender until the pipeline has fully drained
				wait_quiet();
				set_collider(rads[ph], hgts[ph], pbs[ph]);
			end
			calm = (ph == 2);
			for (int i = 0; i < 130; i++)
				add_random_pair();
		end
		wait_quiet();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
